[sv/npwr_pkg.sv]
// ---------------------------------------------------------------------------
// npwr_pkg
// Shared constants and types for the nearest point within radius block.
// ---------------------------------------------------------------------------
`default_nettype none

package npwr_pkg;

    // Payload field widths.
    localparam int COORD_W  = 24;
    localparam int IDX_W    = 6;
    localparam int RADIUS_W = 24;
    localparam int OPCODE_W = 2;

    // Default table depth.
    localparam int NUM_POINTS_DEF = 64;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 2;

    typedef logic [OPCODE_W-1:0]  t_opcode;
    typedef logic [REG_IDX_W-1:0] t_reg_idx;

    localparam t_opcode OP_LOAD  = 2'd0;
    localparam t_opcode OP_QUERY = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;

    localparam t_reg_idx REG_RADIUS = 2'd0;
    localparam t_reg_idx REG_FIRST  = 2'd1;
    localparam t_reg_idx REG_LAST   = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd5120;
    localparam logic [IDX_W-1:0]    FIRST_RST  = 6'd1;
    localparam logic [IDX_W-1:0]    LAST_RST   = 6'd62;

endpackage : npwr_pkg

`default_nettype wire

[sv/npwr_ram.sv]
// ---------------------------------------------------------------------------
// npwr_ram
// Generic single write port, single read port RAM with a registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module npwr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule : npwr_ram

`default_nettype wire

[sv/nearest_point_within_radius_top.sv]
// ---------------------------------------------------------------------------
// nearest_point_within_radius_top
// Searches a table of 2D points for the one nearest to a query position and
// strictly inside a configurable radius; reports its index and distance.
// ---------------------------------------------------------------------------
// A load, clear or ignored transaction leaves the controller idle. A query scans
// its entries with one RAM read per cycle and three stages behind the read, takes
// a square root when an entry is found and then presents the result; the next
// transaction is taken in the cycle in which the result appears. Synchronous
// active-low reset restores the register defaults and clears the nearest entry;
// the point table has none.
`default_nettype none

module nearest_point_within_radius_top
    import npwr_pkg::*;
#(
    parameter int NUM_POINTS = NUM_POINTS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Input transactions.
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OPCODE_W-1:0]   i_opcode,
    input  wire logic [IDX_W-1:0]      i_entry_index,
    input  wire logic [COORD_W-1:0]    i_coord_x,
    input  wire logic [COORD_W-1:0]    i_coord_z,

    // Result transactions.
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_found,
    output logic [IDX_W-1:0]           o_nearest_index,
    output logic [RADIUS_W-1:0]        o_nearest_distance,
    output logic                       o_changed,

    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    // Address width of the table, and a scan counter wide enough for both the
    // table address and the six bit index fields.
    localparam int AW     = $clog2(NUM_POINTS);
    localparam int XW     = (AW > IDX_W) ? AW : IDX_W;
    localparam int SQ_W   = 2 * COORD_W;
    localparam int RT_W   = SQ_W + 1;
    localparam int STEP_W = $clog2(COORD_W + 1);

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SQRT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // -----------------------------------------------------------------------
    // Configuration registers. pready is tied high, so every access completes
    // in its access cycle. Writes outside the register list are ignored.
    // -----------------------------------------------------------------------
    logic [RADIUS_W-1:0] r_radius;
    logic [IDX_W-1:0]    r_first;
    logic [IDX_W-1:0]    r_last;
    logic                cfg_wr;
    t_reg_idx            cfg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_first  <= FIRST_RST;
            r_last   <= LAST_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_RADIUS: r_radius <= pwdata[RADIUS_W-1:0];
                REG_FIRST:  r_first  <= pwdata[IDX_W-1:0];
                REG_LAST:   r_last   <= pwdata[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_RADIUS: prdata = APB_DATA_W'(r_radius);
            REG_FIRST:  prdata = APB_DATA_W'(r_first);
            REG_LAST:   prdata = APB_DATA_W'(r_last);
            default:    prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Point table: x and z share one RAM word. Loads write it only while the
    // controller is idle and queries use its read data only while scanning, so
    // reads that a scan uses never overlap writes and no forwarding is needed.
    // -----------------------------------------------------------------------
    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic                  in_acc;
    logic                  slot_ok;
    logic                  ram_we;
    logic [XW-1:0]         slot_ext;
    logic [XW-1:0]         r_scan_idx;
    logic [SQ_W-1:0]       ram_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign slot_ok    = 32'(i_entry_index) < 32'(NUM_POINTS);
    assign ram_we     = in_acc && (i_opcode == OP_LOAD) && slot_ok;
    assign slot_ext   = XW'(i_entry_index);

    npwr_ram #(
        .WIDTH (SQ_W),
        .DEPTH (NUM_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata ({i_coord_x, i_coord_z}),
        .i_raddr (r_scan_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // -----------------------------------------------------------------------
    // Query set-up. The range is empty when first exceeds last or lies wholly
    // beyond the table; when last lies beyond the table, the scan stops at its last slot.
    // -----------------------------------------------------------------------
    logic          range_empty;
    logic [XW-1:0] last_eff;
    logic [SQ_W-1:0] radius_sq;

    assign range_empty = (r_first > r_last) || (32'(r_first) >= 32'(NUM_POINTS));
    assign last_eff    = (32'(r_last) > 32'(NUM_POINTS - 1)) ? XW'(NUM_POINTS - 1)
                                                             : XW'(r_last);
    assign radius_sq   = SQ_W'(r_radius) * SQ_W'(r_radius);

    // Absolute difference of two signed coordinates; it never exceeds
    // 2^24 - 1, so it fits the coordinate width unsigned.
    function automatic logic [COORD_W-1:0] abs_diff(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] m;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        m = d[COORD_W] ? (~d + 1'b1) : d;
        return m[COORD_W-1:0];
    endfunction

    // -----------------------------------------------------------------------
    // Scan pipeline: read issue, difference, square, compare. Each stage has
    // a valid bit and carries the slot index with it.
    // -----------------------------------------------------------------------
    logic [COORD_W-1:0] r_qx;
    logic [COORD_W-1:0] r_qz;
    logic [XW-1:0]      r_last_eff;
    logic               r_issue;
    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic [IDX_W-1:0]   r_tag1;
    logic [IDX_W-1:0]   r_tag2;
    logic [IDX_W-1:0]   r_tag3;
    logic [COORD_W-1:0] r_dx;
    logic [COORD_W-1:0] r_dz;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqz;
    logic [SQ_W-1:0]    r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic               r_found;
    logic [SQ_W:0]      d2;
    logic               closer;
    logic               scan_end;

    assign d2       = {1'b0, r_sqx} + {1'b0, r_sqz};
    assign closer   = r_v3 && (d2 < {1'b0, r_best});
    assign scan_end = !r_issue && !r_v1 && !r_v2 && !r_v3;

    // -----------------------------------------------------------------------
    // Square root: two bits of the operand per cycle, one root bit per cycle.
    // -----------------------------------------------------------------------
    logic [RT_W-1:0]   r_sq_n;
    logic [RT_W-1:0]   r_sq_res;
    logic [RT_W-1:0]   r_sq_bit;
    logic [STEP_W-1:0] r_sq_cnt;
    logic [RT_W-1:0]   sq_trial;
    logic              sq_take;
    logic              sq_last;
    logic [RADIUS_W-1:0] root_sat;

    assign sq_trial = r_sq_res + r_sq_bit;
    assign sq_take  = r_sq_n >= sq_trial;
    assign sq_last  = (r_sq_cnt == STEP_W'(COORD_W - 1));
    assign root_sat = (|r_sq_res[RT_W-1:RADIUS_W]) ? '1 : r_sq_res[RADIUS_W-1:0];

    // -----------------------------------------------------------------------
    // Controller.
    // -----------------------------------------------------------------------
    logic out_free;

    assign out_free = !o_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_opcode == OP_QUERY)) begin
                    n_state = range_empty ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = r_found ? S_SQRT : S_DONE;
                end
            end
            S_SQRT: begin
                if (sq_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Nearest entry remembered between queries.
    logic             r_have;
    logic [IDX_W-1:0] r_last_near;
    logic             changed;

    assign changed = (r_found != r_have) || (r_found && (r_best_idx != r_last_near));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have      <= 1'b0;
            r_last_near <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= r_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            if (in_acc && (i_opcode == OP_QUERY) && !range_empty) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_scan_idx == r_last_eff)) begin
                r_issue <= 1'b0;
            end

            if (in_acc && (i_opcode == OP_CLEAR)) begin
                r_have      <= 1'b0;
                r_last_near <= '0;
            end else if ((r_state == S_DONE) && out_free) begin
                r_have      <= r_found;
                r_last_near <= r_best_idx;
            end

            if ((r_state == S_DONE) && out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; none of these needs a reset.
    always_ff @(posedge i_clk) begin
        if (in_acc && (i_opcode == OP_QUERY)) begin
            r_qx       <= i_coord_x;
            r_qz       <= i_coord_z;
            r_scan_idx <= XW'(r_first);
            r_last_eff <= last_eff;
            r_best     <= radius_sq;
            r_best_idx <= '0;
            r_found    <= 1'b0;
        end else begin
            if (r_issue && (r_scan_idx != r_last_eff)) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (closer) begin
                r_best     <= d2[SQ_W-1:0];
                r_best_idx <= r_tag3;
                r_found    <= 1'b1;
            end
        end

        r_tag1 <= r_scan_idx[IDX_W-1:0];
        r_tag2 <= r_tag1;
        r_tag3 <= r_tag2;
        r_dx   <= abs_diff(r_qx, ram_rdata[SQ_W-1:COORD_W]);
        r_dz   <= abs_diff(r_qz, ram_rdata[COORD_W-1:0]);
        r_sqx  <= SQ_W'(r_dx) * SQ_W'(r_dx);
        r_sqz  <= SQ_W'(r_dz) * SQ_W'(r_dz);

        if ((r_state == S_SCAN) && scan_end) begin
            r_sq_n   <= RT_W'(r_best);
            r_sq_res <= '0;
            r_sq_bit <= RT_W'(1) << (SQ_W - 2);
            r_sq_cnt <= '0;
        end else if (r_state == S_SQRT) begin
            if (sq_take) begin
                r_sq_n   <= r_sq_n - sq_trial;
                r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
            end else begin
                r_sq_res <= r_sq_res >> 1;
            end
            r_sq_bit <= r_sq_bit >> 2;
            r_sq_cnt <= r_sq_cnt + 1'b1;
        end

        if ((r_state == S_DONE) && out_free) begin
            o_found            <= r_found;
            o_nearest_index    <= r_found ? r_best_idx : '0;
            o_nearest_distance <= r_found ? root_sat : '0;
            o_changed          <= changed;
        end
    end

endmodule : nearest_point_within_radius_top

`default_nettype wire

[sv/npwr_checker.sv]
// ---------------------------------------------------------------------------
// npwr_checker
// Port-level checks on the result channel of the nearest point block.
// ---------------------------------------------------------------------------
`default_nettype none

module npwr_checker
    import npwr_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic                o_found,
    input wire logic [IDX_W-1:0]    o_nearest_index,
    input wire logic [RADIUS_W-1:0] o_nearest_distance,
    input wire logic                o_changed
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_found) && $stable(o_nearest_index)
            && $stable(o_nearest_distance) && $stable(o_changed))
        else $error("result changed while stalled");

    // A miss reports index and distance as zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_nearest_index == '0) && (o_nearest_distance == '0))
        else $error("miss with non-zero index or distance");

    // No result is pending after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // No transaction yields a result in the cycle right after it is taken.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule : npwr_checker

bind nearest_point_within_radius_top npwr_checker u_npwr_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_found            (o_found),
    .o_nearest_index    (o_nearest_index),
    .o_nearest_distance (o_nearest_distance),
    .o_changed          (o_changed)
);

`default_nettype wire
